// ===== src/sbal_pkg.sv =====
`default_nettype none
package sbal_pkg;

   localparam int BLOCKS_PER_SLAB = 16;
   localparam int MAX_SLABS       = 16;

   localparam int SLAB_W   = $clog2(MAX_SLABS);
   localparam int BLK_W    = $clog2(BLOCKS_PER_SLAB);
   localparam int LINK_W   = $clog2(MAX_SLABS + 1);
   localparam int NEXT_W   = $clog2(BLOCKS_PER_SLAB + 1);
   localparam int CNT_W    = $clog2(BLOCKS_PER_SLAB + 1);
   localparam int ADDR_W   = SLAB_W + BLK_W;
   localparam int FIELD_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic [LINK_W-1:0] NO_SLAB   = LINK_W'(MAX_SLABS);
   localparam logic [NEXT_W-1:0] END_BLOCK = NEXT_W'(BLOCKS_PER_SLAB);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(BLOCKS_PER_SLAB);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED = 2'd0,
      ST_FREED     = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_INVALID   = 2'd3
   } status_code_type;

   typedef struct packed {
      logic            capture;
      logic            take_recyc;
      logic            create;
      logic            fill;
      logic            pop_read;
      logic            pop_commit;
      logic            free_commit;
      logic            set_code;
      status_code_type code;
      logic            rsp_load;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic avail_ok;
      logic recyc_ok;
      logic can_create;
      logic pop_ok;
      logic free_ok;
      logic fill_last;
      logic rsp_free;
   } flags_type;

endpackage
`default_nettype wire

// ===== src/sbal_req_if.sv =====
`default_nettype none
interface sbal_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [sbal_pkg::FIELD_W-1:0] free_slab;
   logic [sbal_pkg::FIELD_W-1:0] free_block;

   modport source (output valid, action, free_slab, free_block, input ready);
   modport sink (input valid, action, free_slab, free_block, output ready);
endinterface
`default_nettype wire

// ===== src/sbal_rsp_if.sv =====
`default_nettype none
interface sbal_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbal_pkg::STATUS_W-1:0] status;
   logic [sbal_pkg::FIELD_W-1:0]  given_slab;
   logic [sbal_pkg::FIELD_W-1:0]  given_block;

   modport source (output valid, status, given_slab, given_block, input ready);
   modport sink (input valid, status, given_slab, given_block, output ready);
endinterface
`default_nettype wire

// ===== src/sbal_ram.sv =====
`default_nettype none
module sbal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== src/sbal_ctrl.sv =====
`default_nettype none
module sbal_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sbal_pkg::flags_type flags,
   output sbal_pkg::cmd_type        cmd
);
   import sbal_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_ALLOC  = 7'b0000010,
      S_FILL   = 7'b0000100,
      S_POP    = 7'b0001000,
      S_COMMIT = 7'b0010000,
      S_FREE   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_ALLOCATED;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (flags.action == ACT_FREE) begin
               state_in = S_FREE;
            end else if (flags.avail_ok) begin
               state_in = S_POP;
            end else if (flags.recyc_ok) begin
               cmd.take_recyc = 1'b1;
               state_in = S_POP;
            end else if (flags.can_create) begin
               cmd.create = 1'b1;
               state_in = S_FILL;
            end else begin
               cmd.set_code = 1'b1;
               cmd.code = ST_NO_SPACE;
               state_in = S_DONE;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (flags.fill_last) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (flags.pop_ok) begin
               cmd.pop_read = 1'b1;
               state_in = S_COMMIT;
            end else begin
               cmd.set_code = 1'b1;
               cmd.code = ST_NO_SPACE;
               state_in = S_DONE;
            end
         end
         S_COMMIT: begin
            cmd.pop_commit = 1'b1;
            cmd.set_code = 1'b1;
            cmd.code = ST_ALLOCATED;
            state_in = S_DONE;
         end
         S_FREE: begin
            cmd.set_code = 1'b1;
            if (flags.free_ok) begin
               cmd.free_commit = 1'b1;
               cmd.code = ST_FREED;
            end else begin
               cmd.code = ST_INVALID;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (flags.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/sbal_dp.sv =====
`default_nettype none
module sbal_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_action,
   input  wire logic [sbal_pkg::FIELD_W-1:0]  req_free_slab,
   input  wire logic [sbal_pkg::FIELD_W-1:0]  req_free_block,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [sbal_pkg::STATUS_W-1:0] rsp_status,
   output logic      [sbal_pkg::FIELD_W-1:0]  rsp_given_slab,
   output logic      [sbal_pkg::FIELD_W-1:0]  rsp_given_block,
   input  wire sbal_pkg::cmd_type             cmd,
   output sbal_pkg::flags_type                flags
);
   import sbal_pkg::*;

   localparam int CMP_W = LINK_W + FIELD_W + NEXT_W;

   logic [NEXT_W-1:0] head_ff [MAX_SLABS];
   logic [NEXT_W-1:0] head_in [MAX_SLABS];
   logic [CNT_W-1:0]  used_ff [MAX_SLABS];
   logic [CNT_W-1:0]  used_in [MAX_SLABS];
   logic [LINK_W-1:0] prev_ff [MAX_SLABS];
   logic [LINK_W-1:0] prev_in [MAX_SLABS];
   logic [LINK_W-1:0] next_ff [MAX_SLABS];
   logic [LINK_W-1:0] next_in [MAX_SLABS];

   logic [LINK_W-1:0] avail_ff, avail_in, full_ff, full_in, recyc_ff, recyc_in;
   logic [LINK_W-1:0] created_ff, created_in;

   logic                 action_ff;
   logic [FIELD_W-1:0]   in_slab_ff, in_block_ff;
   logic [SLAB_W-1:0]    cur_slab_ff, cur_slab_in;
   logic [BLK_W-1:0]     cur_block_ff, cur_block_in;
   logic [NEXT_W-1:0]    fill_ff, fill_in;
   status_code_type      code_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [FIELD_W-1:0]   rsp_slab_ff, rsp_block_ff;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
   logic [NEXT_W-1:0]    mem_wdata, mem_rdata;

   logic [SLAB_W-1:0]    av_idx, fr_idx, new_idx;
   logic [NEXT_W-1:0]    av_head;
   logic [CNT_W-1:0]     av_used, cnt_inc;
   logic [LINK_W-1:0]    nx, pv, nrec;

   sbal_ram #(
      .WIDTH (NEXT_W),
      .DEPTH (MAX_SLABS * BLOCKS_PER_SLAB)
   ) u_next_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign av_idx  = avail_ff[SLAB_W-1:0];
   assign fr_idx  = in_slab_ff[SLAB_W-1:0];
   assign new_idx = created_ff[SLAB_W-1:0];
   assign av_head = head_ff[av_idx];
   assign av_used = used_ff[av_idx];
   assign cnt_inc = used_ff[cur_slab_ff] + CNT_W'(1);

   always_comb begin
      flags.action     = action_ff;
      flags.avail_ok   = avail_ff < NO_SLAB;
      flags.recyc_ok   = recyc_ff < NO_SLAB;
      flags.can_create = created_ff < NO_SLAB;
      flags.pop_ok     = (av_head < END_BLOCK) && (av_used < FULL_CNT);
      flags.free_ok    = (CMP_W'(in_slab_ff) < CMP_W'(created_ff))
                         && (CMP_W'(in_block_ff) < CMP_W'(BLOCKS_PER_SLAB))
                         && (used_ff[fr_idx] != '0);
      flags.fill_last  = fill_ff == END_BLOCK - NEXT_W'(1);
      flags.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {cur_slab_ff, fill_ff[BLK_W-1:0]};
      mem_wdata = fill_ff + NEXT_W'(1);
      mem_raddr = {av_idx, av_head[BLK_W-1:0]};
      if (cmd.fill) begin
         mem_we = 1'b1;
      end else if (cmd.free_commit) begin
         mem_we    = 1'b1;
         mem_waddr = {fr_idx, in_block_ff[BLK_W-1:0]};
         mem_wdata = head_ff[fr_idx];
      end
   end

   always_comb begin
      head_in      = head_ff;
      used_in      = used_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      avail_in     = avail_ff;
      full_in      = full_ff;
      recyc_in     = recyc_ff;
      created_in   = created_ff;
      cur_slab_in  = cur_slab_ff;
      cur_block_in = cur_block_ff;
      fill_in      = fill_ff;
      nx   = next_ff[cur_slab_ff];
      pv   = prev_ff[fr_idx];
      nrec = next_ff[fr_idx];

      if (cmd.take_recyc) begin
         avail_in = recyc_ff;
         recyc_in = NO_SLAB;
      end

      if (cmd.create) begin
         cur_slab_in      = new_idx;
         created_in       = created_ff + LINK_W'(1);
         head_in[new_idx] = '0;
         used_in[new_idx] = '0;
         prev_in[new_idx] = NO_SLAB;
         next_in[new_idx] = avail_ff;
         avail_in         = LINK_W'(new_idx);
         fill_in          = '0;
      end

      if (cmd.fill) begin
         fill_in = fill_ff + NEXT_W'(1);
      end

      if (cmd.pop_read) begin
         cur_slab_in  = av_idx;
         cur_block_in = av_head[BLK_W-1:0];
      end

      if (cmd.pop_commit) begin
         head_in[cur_slab_ff] = mem_rdata;
         used_in[cur_slab_ff] = cnt_inc;
         if (cnt_inc == FULL_CNT) begin
            avail_in = nx;
            if (nx < NO_SLAB) begin
               prev_in[nx[SLAB_W-1:0]] = NO_SLAB;
            end
            if (full_ff < NO_SLAB) begin
               prev_in[full_ff[SLAB_W-1:0]] = LINK_W'(cur_slab_ff);
            end
            prev_in[cur_slab_ff] = NO_SLAB;
            next_in[cur_slab_ff] = full_ff;
            full_in = LINK_W'(cur_slab_ff);
         end
      end

      if (cmd.free_commit) begin
         head_in[fr_idx] = NEXT_W'(in_block_ff[BLK_W-1:0]);
         used_in[fr_idx] = used_ff[fr_idx] - CNT_W'(1);
         if (used_ff[fr_idx] == FULL_CNT) begin
            if (nrec < NO_SLAB) begin
               prev_in[nrec[SLAB_W-1:0]] = pv;
            end
            if (pv < NO_SLAB) begin
               next_in[pv[SLAB_W-1:0]] = nrec;
            end else begin
               full_in = nrec;
            end
            if (recyc_ff < NO_SLAB) begin
               prev_in[recyc_ff[SLAB_W-1:0]] = LINK_W'(fr_idx);
            end
            prev_in[fr_idx] = NO_SLAB;
            next_in[fr_idx] = recyc_ff;
            recyc_in = LINK_W'(fr_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff     <= NO_SLAB;
         full_ff      <= NO_SLAB;
         recyc_ff     <= NO_SLAB;
         created_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SLABS; i++) begin
            used_ff[i] <= '0;
         end
      end else begin
         avail_ff   <= avail_in;
         full_ff    <= full_in;
         recyc_ff   <= recyc_in;
         created_ff <= created_in;
         used_ff    <= used_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      cur_slab_ff  <= cur_slab_in;
      cur_block_ff <= cur_block_in;
      fill_ff      <= fill_in;
      if (cmd.capture) begin
         action_ff   <= req_action;
         in_slab_ff  <= req_free_slab;
         in_block_ff <= req_free_block;
      end
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= code_ff;
         if (code_ff == ST_ALLOCATED) begin
            rsp_slab_ff  <= FIELD_W'(cur_slab_ff);
            rsp_block_ff <= FIELD_W'(cur_block_ff);
         end else begin
            rsp_slab_ff  <= '0;
            rsp_block_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_given_slab  = rsp_slab_ff;
   assign rsp_given_block = rsp_block_ff;
endmodule
`default_nettype wire

// ===== src/slab_block_allocator_unit.sv =====
// Slab block allocator: hands out (slab, block) handles from up to 16 slabs of
// 16 blocks and takes them back. One item is in work at a time. An allocate
// that has to create a new slab first writes that slab's free list into the
// next-block RAM one entry per cycle. The next item is accepted in the cycle
// after the result is loaded. The result sits in an output register, so the
// next item is taken while it waits; a further result waits only if that one
// is still held.
`default_nettype none
module slab_block_allocator_unit (
   input wire logic clock,
   input wire logic reset,
   sbal_req_if.sink   req_ch,
   sbal_rsp_if.source rsp_ch
);
   import sbal_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   sbal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   sbal_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_ch.action),
      .req_free_slab   (req_ch.free_slab),
      .req_free_block  (req_ch.free_block),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_given_slab  (rsp_ch.given_slab),
      .rsp_given_block (rsp_ch.given_block),
      .cmd             (cmd),
      .flags           (flags)
   );
endmodule
`default_nettype wire
